// ===== sv/lps_pkg.sv =====
// Package for the line pixel stepper: default coordinate width, request opcodes
// and row direction codes. No dependencies.
`default_nettype none

package lps_pkg;

   localparam int COORD_BITS_DEF = 12;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ROW_HOLD = 2'd0,
      ROW_UP   = 2'd1,
      ROW_DOWN = 2'd2
   } row_dir_type;

endpackage

`default_nettype wire

// ===== sv/lps_req_if.sv =====
// Request channel of the line pixel stepper: valid/ready plus the load
// and step payload. Depends on lps_pkg for the default coordinate width.
`default_nettype none

interface lps_req_if #(
   parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic                  opcode;
   logic [COORD_BITS-1:0] start_x;
   logic [COORD_BITS-1:0] start_y;
   logic [COORD_BITS-1:0] finish_x;
   logic [COORD_BITS-1:0] finish_y;

   modport source (output valid, output opcode, output start_x, output start_y,
                   output finish_x, output finish_y, input ready);
   modport sink   (input valid, input opcode, input start_x, input start_y,
                   input finish_x, input finish_y, output ready);
endinterface

`default_nettype wire

// ===== sv/lps_rsp_if.sv =====
// Result channel of the line pixel stepper: valid/ready plus one pixel.
// Depends on lps_pkg for the default coordinate width.
`default_nettype none

interface lps_rsp_if #(
   parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) ();
   logic                  valid;
   logic                  ready;
   logic [COORD_BITS-1:0] pixel_x;
   logic [COORD_BITS-1:0] pixel_y;
   logic                  last_pixel;

   modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                   input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, input last_pixel,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/line_pixel_stepper_top.sv =====
// X-major line rasterizer: loads two endpoints, then emits at most one pixel per
// step request. Depends on lps_pkg, lps_req_if and lps_rsp_if.
//
//   channel   dir   handshake      payload
//   req_bus   in    valid/ready    opcode, start_x, start_y, finish_x, finish_y
//   rsp_bus   out   valid/ready    pixel_x, pixel_y, last_pixel
//
// One request is taken per cycle unless a held result stalls it; a step's
// pixel appears in the result register the cycle after it is accepted. The
// per-step work is an add, compare and subtract on the error term.
// Reset (synchronous) clears the line state; no line is active afterwards.
// A held result stalls new requests only while rsp_bus.ready is low.
`default_nettype none

module line_pixel_stepper_top #(
   parameter int COORD_BITS = lps_pkg::COORD_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lps_req_if.sink    req_bus,
   lps_rsp_if.source  rsp_bus
);
   import lps_pkg::*;

   localparam int SPAN_BITS = COORD_BITS + 1;
   localparam int ERR_BITS  = 2 * COORD_BITS + 1;

   logic                  line_active_ff, line_active_in;
   logic [COORD_BITS-1:0] cur_col_ff, cur_col_in;
   logic [COORD_BITS-1:0] cur_row_ff, cur_row_in;
   logic [COORD_BITS-1:0] stop_col_ff, stop_col_in;
   logic [ERR_BITS-1:0]   accum_err_ff, accum_err_in;
   logic [SPAN_BITS-1:0]  span_x_ff, span_x_in;
   logic [SPAN_BITS-1:0]  span_y_ff, span_y_in;
   row_dir_type           row_dir_ff, row_dir_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] pixel_x_ff, pixel_x_in;
   logic [COORD_BITS-1:0] pixel_y_ff, pixel_y_in;
   logic                  last_pixel_ff, last_pixel_in;

   logic                  accept;
   logic [COORD_BITS-1:0] lx, ly, rx, ry;
   logic                  step_ok, is_last;
   logic [ERR_BITS-1:0]   err_sum, err_red;
   logic                  err_over;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.pixel_x    = pixel_x_ff;
   assign rsp_bus.pixel_y    = pixel_y_ff;
   assign rsp_bus.last_pixel = last_pixel_ff;

   // order endpoints so x rises
   always_comb begin
      if (req_bus.start_x < req_bus.finish_x) begin
         lx = req_bus.start_x;  ly = req_bus.start_y;
         rx = req_bus.finish_x; ry = req_bus.finish_y;
      end else begin
         lx = req_bus.finish_x; ly = req_bus.finish_y;
         rx = req_bus.start_x;  ry = req_bus.start_y;
      end
   end

   assign step_ok  = line_active_ff && (cur_col_ff < stop_col_ff);
   assign is_last  = ({1'b0, cur_col_ff} + SPAN_BITS'(1)) == {1'b0, stop_col_ff};
   assign err_sum  = accum_err_ff + ERR_BITS'(span_y_ff);
   assign err_over = err_sum >= ERR_BITS'(span_x_ff);
   assign err_red  = err_sum - ERR_BITS'(span_x_ff);

   always_comb begin
      line_active_in = line_active_ff;
      cur_col_in     = cur_col_ff;
      cur_row_in     = cur_row_ff;
      stop_col_in    = stop_col_ff;
      accum_err_in   = accum_err_ff;
      span_x_in      = span_x_ff;
      span_y_in      = span_y_ff;
      row_dir_in     = row_dir_ff;
      pixel_x_in     = pixel_x_ff;
      pixel_y_in     = pixel_y_ff;
      last_pixel_in  = last_pixel_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;

      if (accept) begin
         if (req_bus.opcode == OP_LOAD) begin
            span_x_in = {1'b0, rx} - {1'b0, lx} + SPAN_BITS'(1);
            if (ry > ly) begin
               span_y_in  = {1'b0, ry} - {1'b0, ly} + SPAN_BITS'(1);
               row_dir_in = ROW_UP;
            end else if (ry < ly) begin
               span_y_in  = {1'b0, ly} - {1'b0, ry} + SPAN_BITS'(1);
               row_dir_in = ROW_DOWN;
            end else begin
               span_y_in  = SPAN_BITS'(1);
               row_dir_in = ROW_HOLD;
            end
            cur_col_in     = lx;
            cur_row_in     = ly;
            stop_col_in    = rx;
            accum_err_in   = '0;
            line_active_in = lx < rx;
         end else if (!step_ok) begin
            line_active_in = 1'b0;
         end else begin
            pixel_x_in    = cur_col_ff;
            pixel_y_in    = cur_row_ff;
            last_pixel_in = is_last;
            rsp_valid_in  = 1'b1;
            if (err_over) begin
               accum_err_in = err_red;
               case (row_dir_ff)
                  ROW_UP:   cur_row_in = cur_row_ff + COORD_BITS'(1);
                  ROW_DOWN: cur_row_in = cur_row_ff - COORD_BITS'(1);
                  default:  cur_row_in = cur_row_ff;
               endcase
            end else begin
               accum_err_in = err_sum;
            end
            cur_col_in = cur_col_ff + COORD_BITS'(1);
            if (is_last) begin
               line_active_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_active_ff <= 1'b0;
         cur_col_ff     <= '0;
         cur_row_ff     <= '0;
         stop_col_ff    <= '0;
         accum_err_ff   <= '0;
         span_x_ff      <= '0;
         span_y_ff      <= '0;
         row_dir_ff     <= ROW_HOLD;
         rsp_valid_ff   <= 1'b0;
      end else begin
         line_active_ff <= line_active_in;
         cur_col_ff     <= cur_col_in;
         cur_row_ff     <= cur_row_in;
         stop_col_ff    <= stop_col_in;
         accum_err_ff   <= accum_err_in;
         span_x_ff      <= span_x_in;
         span_y_ff      <= span_y_in;
         row_dir_ff     <= row_dir_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      pixel_x_ff    <= pixel_x_in;
      pixel_y_ff    <= pixel_y_in;
      last_pixel_ff <= last_pixel_in;
   end

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
// Testbench for line_pixel_stepper_top: sends load and step requests with
// random gaps and stalls, predicts every pixel and checks it field by field.
// Depends on lps_pkg, lps_req_if and lps_rsp_if.

module testbench;
   import lps_pkg::*;

   localparam int CB         = COORD_BITS_DEF;
   localparam int MAX_COORD  = (1 << CB) - 1;
   localparam int ITEMS      = 1600;
   localparam int IDLE_LIMIT = 3000;

   typedef logic [CB-1:0] coord_t;

   class pixel_scoreboard;
      typedef struct {
         coord_t x;
         coord_t y;
         logic   last;
      } pixel_t;

      bit             active;
      coord_t         col;
      coord_t         row;
      coord_t         stop;
      bit [2*CB:0]    err;
      bit [CB:0]      span_x;
      bit [CB:0]      span_y;
      row_dir_type    dir;
      pixel_t         pixel_q[$];
      int             errors;

      function void note_request(opcode_type op, coord_t ax, coord_t ay,
                                 coord_t bx, coord_t by);
         coord_t lx, ly, rx, ry;
         pixel_t p;
         if (op == OP_LOAD) begin
            if (ax < bx) begin
               lx = ax; ly = ay; rx = bx; ry = by;
            end else begin
               lx = bx; ly = by; rx = ax; ry = ay;
            end
            span_x = {1'b0, rx} - {1'b0, lx} + 1'b1;
            span_y = (ry > ly) ? ({1'b0, ry} - {1'b0, ly} + 1'b1)
                               : ({1'b0, ly} - {1'b0, ry} + 1'b1);
            if (ry > ly) dir = ROW_UP;
            else if (ry < ly) dir = ROW_DOWN;
            else dir = ROW_HOLD;
            col    = lx;
            row    = ly;
            stop   = rx;
            err    = '0;
            active = (lx < rx);
         end else if (active && col < stop) begin
            p.x    = col;
            p.y    = row;
            p.last = ({1'b0, col} + 1'b1) == {1'b0, stop};
            pixel_q.push_back(p);
            err = err + span_y;
            if (err >= span_x) begin
               if (dir == ROW_UP) row = row + 1'b1;
               else if (dir == ROW_DOWN) row = row - 1'b1;
               err = err - span_x;
            end
            col = col + 1'b1;
            if (p.last) active = 1'b0;
         end else begin
            active = 1'b0;
         end
      endfunction

      function void check_pixel(coord_t x, coord_t y, logic last);
         pixel_t p;
         if (pixel_q.size() == 0) begin
            $display("%0t: unexpected pixel x=%0d y=%0d last=%0b", $time, x, y, last);
            errors++;
            return;
         end
         p = pixel_q.pop_front();
         if (x !== p.x) begin
            $display("%0t: pixel_x expected %0d actual %0d", $time, p.x, x);
            errors++;
         end
         if (y !== p.y) begin
            $display("%0t: pixel_y expected %0d actual %0d", $time, p.y, y);
            errors++;
         end
         if (last !== p.last) begin
            $display("%0t: last_pixel expected %0b actual %0b", $time, p.last, last);
            errors++;
         end
      endfunction

      function int pending();
         return pixel_q.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   calm;
   int   sent;
   int   idle_cycles;

   pixel_scoreboard sb = new();

   lps_req_if #(.COORD_BITS(CB)) req_bus ();
   lps_rsp_if #(.COORD_BITS(CB)) rsp_bus ();

   line_pixel_stepper_top #(.COORD_BITS(CB)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic coord_t rnd_coord();
      return coord_t'($urandom_range(0, MAX_COORD));
   endfunction

   // Keep valid high across back-to-back requests; drop it only for a gap.
   task automatic send_request(opcode_type op, coord_t ax, coord_t ay,
                               coord_t bx, coord_t by);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.opcode   <= op;
      req_bus.start_x  <= ax;
      req_bus.start_y  <= ay;
      req_bus.finish_x <= bx;
      req_bus.finish_y <= by;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
   endtask

   task automatic send_step();
      send_request(OP_STEP, rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord());
   endtask

   // One load followed by its steps; some runs are cut short or overrun.
   task automatic draw_line();
      int dx, dy, t, steps, r;
      coord_t lx, ly, rx, ry;
      calm = ($urandom_range(0, 6) == 0);
      r = $urandom_range(0, 99);
      if (r < 80) dx = $urandom_range(1, 24);
      else if (r < 94) dx = $urandom_range(25, 300);
      else if (r < 97) dx = 0;
      else dx = $urandom_range(301, MAX_COORD);
      lx = coord_t'($urandom_range(0, MAX_COORD - dx));
      rx = lx + coord_t'(dx);
      ly = rnd_coord();
      if ($urandom_range(0, 1)) begin
         ry = rnd_coord();
      end else begin
         dy = $urandom_range(0, dx + dx / 2 + 1);
         t  = $urandom_range(0, 1) ? int'(ly) + dy : int'(ly) - dy;
         ry = (t < 0) ? coord_t'(0) : ((t > MAX_COORD) ? coord_t'(MAX_COORD) : coord_t'(t));
      end
      if ($urandom_range(0, 1)) send_request(OP_LOAD, lx, ly, rx, ry);
      else send_request(OP_LOAD, rx, ry, lx, ly);
      sent++;
      steps = (dx > 300) ? $urandom_range(1, 60) : dx;
      r = $urandom_range(0, 99);
      if (r < 12) steps = steps + $urandom_range(1, 3);
      else if (r < 25 && steps > 0) steps = $urandom_range(0, steps - 1);
      for (int i = 0; i < steps; i++) begin
         send_step();
         if (i < dx) sent++;
      end
   endtask

   initial begin
      int n;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         n = pick_gap();
         if (n > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (n) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Check results before noting requests so a same-edge request never
   // stands in for a missing pixel.
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            sb.check_pixel(rsp_bus.pixel_x, rsp_bus.pixel_y, rsp_bus.last_pixel);
         if (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)
            sb.note_request(opcode_type'(req_bus.opcode), req_bus.start_x,
                            req_bus.start_y, req_bus.finish_x, req_bus.finish_y);
         if ((rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (req_bus.valid === 1'b1 && req_bus.ready === 1'b1)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("line_pixel_stepper_top verification failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.opcode   <= OP_LOAD;
      req_bus.start_x  <= '0;
      req_bus.start_y  <= '0;
      req_bus.finish_x <= '0;
      req_bus.finish_y <= '0;
      calm = 1'b0;
      sent = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // step with no line loaded, then a vertical line with no pixels
      send_step();
      send_request(OP_LOAD, coord_t'(5), coord_t'(7), coord_t'(5), coord_t'(100));
      send_step();
      // reversed endpoints at the right edge, row falls from the top
      send_request(OP_LOAD, coord_t'(MAX_COORD), coord_t'(0), coord_t'(MAX_COORD - 5),
                   coord_t'(MAX_COORD));
      repeat (5) send_step();
      send_step();
      // flat line on the top row, stepped past its end
      send_request(OP_LOAD, coord_t'(0), coord_t'(MAX_COORD), coord_t'(3),
                   coord_t'(MAX_COORD));
      repeat (3) send_step();
      send_step();
      // full-width diagonal, cut off by a steep rising line
      send_request(OP_LOAD, coord_t'(0), coord_t'(0), coord_t'(MAX_COORD),
                   coord_t'(MAX_COORD));
      repeat (3) send_step();
      send_request(OP_LOAD, coord_t'(10), coord_t'(0), coord_t'(14), coord_t'(MAX_COORD));
      repeat (4) send_step();

      while (sent < ITEMS) begin
         if ($urandom_range(0, 99) < 8) begin
            send_request(opcode_type'($urandom_range(0, 1)), rnd_coord(), rnd_coord(),
                         rnd_coord(), rnd_coord());
            sent++;
         end else begin
            draw_line();
         end
      end
      req_bus.valid <= 1'b0;
      calm = 1'b0;

      // let the monitor note the last request before draining
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("line_pixel_stepper_top verification clean");
      end else begin
         $display("line_pixel_stepper_top verification failed");
      end
      $finish;
   end

endmodule

// ===== line_pixel_stepper_top.f =====
sv/lps_pkg.sv
sv/lps_req_if.sv
sv/lps_rsp_if.sv
sv/line_pixel_stepper_top.sv
dv/testbench.sv
